[rtl/gsa_pkg.sv]
// ----------------------------------------------------------------------------
// gsa_pkg
// Request and status codes, field widths and the result record of the
// generational slot allocator.
// ----------------------------------------------------------------------------
package gsa_pkg;

  localparam int REQ_W = 2;
  localparam int ST_W  = 2;
  localparam int IDX_W = 8;
  localparam int GEN_W = 16;
  localparam int CNT_W = 8;

  typedef logic [REQ_W-1:0] req_t;
  typedef logic [ST_W-1:0]  status_t;

  localparam req_t REQ_ALLOC   = 2'd0;
  localparam req_t REQ_RELEASE = 2'd1;
  localparam req_t REQ_CHECK   = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_FULL    = 2'd1;
  localparam status_t ST_INVALID = 2'd2;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] slot_index;
    logic [GEN_W-1:0] slot_gen;
    logic [CNT_W-1:0] used_count;
  } result_t;

endpackage

[rtl/gsa_link_store.sv]
// ----------------------------------------------------------------------------
// gsa_link_store
// Free-list link memory. Slots never handed out read as their reset link,
// judged against the controller's fill mark, the last slot by a write flag.
// ----------------------------------------------------------------------------
module gsa_link_store #(
  parameter int SLOTS = 256,
  parameter int IW    = 8,
  parameter int FW    = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic [IW-1:0] rd_link,
  input  logic          wr_en,
  input  logic [IW-1:0] wr_addr,
  input  logic [IW-1:0] wr_data,
  input  logic [FW-1:0] fresh
);

  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  logic [IW-1:0] mem [SLOTS];
  logic [IW-1:0] rd_data_r;
  logic [IW-1:0] rd_addr_r;
  logic          last_wr_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_wr_r <= 1'b0;
    end else if (wr_en && wr_addr == LAST_SLOT) begin
      last_wr_r <= 1'b1;
    end
  end

  always_comb begin
    if (rd_addr_r == LAST_SLOT) begin
      rd_link = last_wr_r ? rd_data_r : '0;
    end else if (FW'(rd_addr_r) < fresh) begin
      rd_link = rd_data_r;
    end else begin
      rd_link = rd_addr_r + IW'(1);
    end
  end

endmodule

[rtl/gsa_slot_store.sv]
// ----------------------------------------------------------------------------
// gsa_slot_store
// Per-slot in-use flag and generation memory. Slots at or above the fill mark
// read as free with generation zero.
// ----------------------------------------------------------------------------
module gsa_slot_store #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16,
  parameter int IW       = 8,
  parameter int FW       = 9
) (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [IW-1:0]       rd_addr,
  output logic                rd_used,
  output logic [GEN_BITS-1:0] rd_gen,
  input  logic                wr_en,
  input  logic [IW-1:0]       wr_addr,
  input  logic                wr_used,
  input  logic [GEN_BITS-1:0] wr_gen,
  input  logic [FW-1:0]       fresh
);

  logic [GEN_BITS:0] mem [SLOTS];
  logic [GEN_BITS:0] rd_data_r;
  logic [IW-1:0]     rd_addr_r;
  logic              seen;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_used, wr_gen};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  assign seen    = FW'(rd_addr_r) < fresh;
  assign rd_used = seen ? rd_data_r[GEN_BITS] : 1'b0;
  assign rd_gen  = seen ? rd_data_r[GEN_BITS-1:0] : '0;

endmodule

[rtl/gsa_ctrl.sv]
// ----------------------------------------------------------------------------
// gsa_ctrl
// Request sequencer: issue the memory reads, validate the handle, update the
// free list and counters, write back and register the result.
// ----------------------------------------------------------------------------
module gsa_ctrl #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16,
  parameter int IW       = 8,
  parameter int FW       = 9
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gsa_pkg::req_t               in_req,
  input  logic [gsa_pkg::IDX_W-1:0]   in_idx,
  input  logic [gsa_pkg::GEN_W-1:0]   in_gen,
  output logic                        out_valid,
  input  logic                        out_ready,
  output gsa_pkg::result_t            out_res,
  output logic                        link_rd_en,
  output logic [IW-1:0]               link_rd_addr,
  input  logic [IW-1:0]               link_rd_data,
  output logic                        link_wr_en,
  output logic [IW-1:0]               link_wr_addr,
  output logic [IW-1:0]               link_wr_data,
  output logic                        slot_rd_en,
  output logic [IW-1:0]               slot_rd_addr,
  input  logic                        slot_rd_used,
  input  logic [GEN_BITS-1:0]         slot_rd_gen,
  output logic                        slot_wr_en,
  output logic [IW-1:0]               slot_wr_addr,
  output logic                        slot_wr_used,
  output logic [GEN_BITS-1:0]         slot_wr_gen,
  output logic [FW-1:0]               fresh
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  logic                        state_r, state_nxt;
  logic [IW-1:0]               head_r, head_nxt;
  logic [IW-1:0]               tail_r, tail_nxt;
  logic [IW-1:0]               count_r, count_nxt;
  logic [FW-1:0]               fresh_r, fresh_nxt;
  logic                        out_valid_r, out_valid_nxt;
  gsa_pkg::result_t            out_res_r, out_res_nxt;
  gsa_pkg::req_t               req_r;
  logic [gsa_pkg::IDX_W-1:0]   idx_r;
  logic [gsa_pkg::GEN_W-1:0]   gen_r;

  logic                        accept;
  logic                        exec_done;
  logic                        handle_ok;
  logic [GEN_BITS-1:0]         gen_inc;
  logic [IW-1:0]               req_slot;

  assign in_ready  = state_r == S_IDLE;
  assign accept    = in_valid && in_ready;
  assign exec_done = state_r == S_EXEC && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign fresh     = fresh_r;

  assign link_rd_en   = accept;
  assign link_rd_addr = head_r;
  assign slot_rd_en   = accept;
  assign slot_rd_addr = (in_req == gsa_pkg::REQ_ALLOC) ? head_r : IW'(in_idx);

  assign req_slot  = IW'(idx_r);
  assign gen_inc   = slot_rd_gen + GEN_BITS'(1);
  assign handle_ok = idx_r != '0 && 32'(idx_r) < 32'(SLOTS) && slot_rd_used &&
                     32'(gen_r) == 32'(slot_rd_gen);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
      idx_r <= in_idx;
      gen_r <= in_gen;
    end
    out_res_r <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= IW'(1);
      tail_r      <= LAST_SLOT;
      count_r     <= '0;
      fresh_r     <= FW'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    fresh_nxt     = fresh_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_res_nxt   = out_res_r;
    link_wr_en    = 1'b0;
    link_wr_addr  = head_r;
    link_wr_data  = '0;
    slot_wr_en    = 1'b0;
    slot_wr_addr  = head_r;
    slot_wr_used  = 1'b0;
    slot_wr_gen   = slot_rd_gen;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_done) begin
          state_nxt                = S_IDLE;
          out_valid_nxt            = 1'b1;
          out_res_nxt.status       = gsa_pkg::ST_INVALID;
          out_res_nxt.slot_index   = '0;
          out_res_nxt.slot_gen     = '0;
          case (req_r)
            gsa_pkg::REQ_ALLOC: begin
              if (head_r == '0) begin
                out_res_nxt.status = gsa_pkg::ST_FULL;
              end else begin
                head_nxt     = link_rd_data;
                if (link_rd_data == '0) begin
                  tail_nxt = '0;
                end
                link_wr_en   = 1'b1;
                link_wr_addr = head_r;
                link_wr_data = '0;
                slot_wr_en   = 1'b1;
                slot_wr_addr = head_r;
                slot_wr_used = 1'b1;
                slot_wr_gen  = gen_inc;
                count_nxt    = count_r + IW'(1);
                if (FW'(head_r) == fresh_r) begin
                  fresh_nxt = fresh_r + FW'(1);
                end
                out_res_nxt.status     = gsa_pkg::ST_OK;
                out_res_nxt.slot_index = gsa_pkg::IDX_W'(head_r);
                out_res_nxt.slot_gen   = gsa_pkg::GEN_W'(gen_inc);
              end
            end
            gsa_pkg::REQ_RELEASE: begin
              if (handle_ok) begin
                slot_wr_en   = 1'b1;
                slot_wr_addr = req_slot;
                slot_wr_used = 1'b0;
                slot_wr_gen  = slot_rd_gen;
                if (tail_r != '0) begin
                  link_wr_en   = 1'b1;
                  link_wr_addr = tail_r;
                  link_wr_data = req_slot;
                end else begin
                  head_nxt = req_slot;
                end
                tail_nxt  = req_slot;
                count_nxt = count_r - IW'(1);
                out_res_nxt.status     = gsa_pkg::ST_OK;
                out_res_nxt.slot_index = idx_r;
                out_res_nxt.slot_gen   = gsa_pkg::GEN_W'(slot_rd_gen);
              end
            end
            gsa_pkg::REQ_CHECK: begin
              if (handle_ok) begin
                out_res_nxt.status     = gsa_pkg::ST_OK;
                out_res_nxt.slot_index = idx_r;
                out_res_nxt.slot_gen   = gsa_pkg::GEN_W'(slot_rd_gen);
              end
            end
            default: begin
              out_res_nxt.status = gsa_pkg::ST_INVALID;
            end
          endcase
          out_res_nxt.used_count = gsa_pkg::CNT_W'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted beat did not enter execute");

  a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == '0) == (tail_r == '0))
    else $error("free list head and tail disagree on empty");

  a_alloc_ok: assert property (@(posedge clk) disable iff (!rst_n)
    exec_done && req_r == gsa_pkg::REQ_ALLOC && head_r != '0
      |=> out_res_r.status == gsa_pkg::ST_OK)
    else $error("allocate from non-empty list failed");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_EXEC))
    else $error("result beat raised outside execute");

  a_fresh_nz: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r != '0)
    else $error("fill mark lost");
`endif

endmodule

[rtl/generational_slot_allocator_unit.sv]
// ----------------------------------------------------------------------------
// generational_slot_allocator_unit
// Handle allocator over a fixed pool of slots with a FIFO free list and
// per-slot generation counters.
// ----------------------------------------------------------------------------
// Each request is accepted in idle, which issues the reads of the link and
// slot memories (registered read ports); execute then validates, updates
// the free list and writes back. The next request waits for idle again.
// The result sits in an output register, and the execute cycle waits while
// an earlier result is still untaken. No clearing pass runs after reset: a
// fill mark of slots never handed out makes those read as their reset value.
module generational_slot_allocator_unit #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // handle_index, handle_gen
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // slot_index, slot_gen, used_count
  output logic [1:0]  out_tuser   // status
);

  localparam int IW = $clog2(SLOTS);
  localparam int FW = $clog2(SLOTS + 1);

  gsa_pkg::result_t    res;
  logic                link_rd_en;
  logic [IW-1:0]       link_rd_addr;
  logic [IW-1:0]       link_rd_data;
  logic                link_wr_en;
  logic [IW-1:0]       link_wr_addr;
  logic [IW-1:0]       link_wr_data;
  logic                slot_rd_en;
  logic [IW-1:0]       slot_rd_addr;
  logic                slot_rd_used;
  logic [GEN_BITS-1:0] slot_rd_gen;
  logic                slot_wr_en;
  logic [IW-1:0]       slot_wr_addr;
  logic                slot_wr_used;
  logic [GEN_BITS-1:0] slot_wr_gen;
  logic [FW-1:0]       fresh;

  gsa_ctrl #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS),
    .IW       (IW),
    .FW       (FW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_req       (in_tuser),
    .in_idx       (in_tdata[7:0]),
    .in_gen       (in_tdata[23:8]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .out_res      (res),
    .link_rd_en   (link_rd_en),
    .link_rd_addr (link_rd_addr),
    .link_rd_data (link_rd_data),
    .link_wr_en   (link_wr_en),
    .link_wr_addr (link_wr_addr),
    .link_wr_data (link_wr_data),
    .slot_rd_en   (slot_rd_en),
    .slot_rd_addr (slot_rd_addr),
    .slot_rd_used (slot_rd_used),
    .slot_rd_gen  (slot_rd_gen),
    .slot_wr_en   (slot_wr_en),
    .slot_wr_addr (slot_wr_addr),
    .slot_wr_used (slot_wr_used),
    .slot_wr_gen  (slot_wr_gen),
    .fresh        (fresh)
  );

  gsa_link_store #(
    .SLOTS (SLOTS),
    .IW    (IW),
    .FW    (FW)
  ) u_link (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_link (link_rd_data),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data),
    .fresh   (fresh)
  );

  gsa_slot_store #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS),
    .IW       (IW),
    .FW       (FW)
  ) u_slot (
    .clk     (clk),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_used (slot_rd_used),
    .rd_gen  (slot_rd_gen),
    .wr_en   (slot_wr_en),
    .wr_addr (slot_wr_addr),
    .wr_used (slot_wr_used),
    .wr_gen  (slot_wr_gen),
    .fresh   (fresh)
  );

  assign out_tdata = {res.used_count, res.slot_gen, res.slot_index};
  assign out_tuser = res.status;

endmodule
